>>> hw/rtl/p2rgba_pkg.sv
// ----------------------------------------------------------------------------
// p2rgba_pkg
// Shared types and constants for the palette index to packed rgba expander.
// ----------------------------------------------------------------------------
package p2rgba_pkg;

  // palette size and derived address width
  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int INDEX_W         = 8;
  localparam int BYTE_W          = 8;

  // command codes of an input transaction
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  // one palette entry as held in the store
  typedef struct packed {
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte0;
  } pal_entry_t;

  // status of the lookup stage
  typedef struct packed {
    logic valid;
    logic oor;
  } lookup_stat_t;

endpackage

>>> hw/rtl/p2rgba_in_if.sv
// ----------------------------------------------------------------------------
// p2rgba_in_if
// Input channel: palette load or pixel lookup transaction.
// ----------------------------------------------------------------------------
interface p2rgba_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] color_index;
  logic [7:0] entry_byte0;
  logic [7:0] entry_byte1;
  logic [7:0] entry_byte2;
  logic [7:0] entry_alpha;

  modport source (
    output valid, command, color_index, entry_byte0, entry_byte1, entry_byte2,
    entry_alpha,
    input  ready
  );

  modport sink (
    input  valid, command, color_index, entry_byte0, entry_byte1, entry_byte2,
    entry_alpha,
    output ready
  );
endinterface

>>> hw/rtl/p2rgba_out_if.sv
// ----------------------------------------------------------------------------
// p2rgba_out_if
// Result channel: one packed pixel per transaction.
// ----------------------------------------------------------------------------
interface p2rgba_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] alpha_byte;
  logic       alpha_present;

  modport source (
    output valid, first_byte, second_byte, third_byte, alpha_byte, alpha_present,
    input  ready
  );

  modport sink (
    input  valid, first_byte, second_byte, third_byte, alpha_byte, alpha_present,
    output ready
  );
endinterface

>>> hw/rtl/palette_index_to_packed_rgba_top.sv
// ----------------------------------------------------------------------------
// palette_index_to_packed_rgba_top
// Palette index to packed rgba expander: loads palette entries and converts
// pixel indices into byte2, byte1, byte0, alpha results.
// ----------------------------------------------------------------------------
// pipeline: a pixel result is registered in the lookup stage, then in the output
//   register; throughput: one transaction per cycle, load or pixel, while the
//   output is not stalled; a full lookup stage behind a stalled output holds the input
// reset: clears the lookup and output valid flags and sets output_alpha to 1;
//   palette contents are not cleared and are undefined until loaded
module palette_index_to_packed_rgba_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  p2rgba_in_if.sink    in_ch,
  p2rgba_out_if.source out_ch
);
  import p2rgba_pkg::*;

  logic         output_alpha_r;
  lookup_stat_t lookup_r;
  lookup_stat_t lookup_nxt;
  logic         lookup_take;
  logic         in_accept;
  logic         is_pixel;
  logic         in_range;
  pal_entry_t   wr_entry;
  pal_entry_t   rd_data;
  logic         clear_color;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_alpha_r <= 1'b1;
    end else if (cfg_wr_en) begin
      output_alpha_r <= cfg_wr_data;
    end
  end

  // input decode
  assign in_ch.ready = !lookup_r.valid || lookup_take;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign is_pixel    = (in_ch.command == CMD_PIXEL);
  assign in_range    = {1'b0, in_ch.color_index} < (INDEX_W + 1)'(PALETTE_ENTRIES);

  // zero alpha clears the colour bytes of a loaded entry
  assign clear_color    = (in_ch.entry_alpha == '0);
  assign wr_entry.alpha = in_ch.entry_alpha;
  assign wr_entry.byte2 = clear_color ? '0 : in_ch.entry_byte2;
  assign wr_entry.byte1 = clear_color ? '0 : in_ch.entry_byte1;
  assign wr_entry.byte0 = clear_color ? '0 : in_ch.entry_byte0;

  p2rgba_palette_mem u_mem (
    .clk     (clk),
    .wr_en   (in_accept && !is_pixel && in_range),
    .wr_addr (in_ch.color_index[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (in_accept && is_pixel && in_range),
    .rd_addr (in_ch.color_index[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // lookup stage status
  always_comb begin
    lookup_nxt = lookup_r;
    if (in_accept) begin
      lookup_nxt.valid = is_pixel;
      lookup_nxt.oor   = !in_range;
    end else if (lookup_take) begin
      lookup_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookup_r <= '0;
    end else begin
      lookup_r <= lookup_nxt;
    end
  end

  p2rgba_format u_format (
    .clk          (clk),
    .rst_n        (rst_n),
    .lookup       (lookup_r),
    .rd_data      (rd_data),
    .output_alpha (output_alpha_r),
    .lookup_take  (lookup_take),
    .out_ch       (out_ch)
  );

  // an accepted pixel occupies the lookup stage in the next cycle
  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && is_pixel |=> lookup_r.valid)
    else $error("accepted pixel did not reach the lookup stage");

  // a load leaves the lookup stage empty
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !is_pixel |=> !lookup_r.valid)
    else $error("load transaction produced a lookup");

  // a full lookup stage behind a stalled output blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_r.valid && out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while the pipeline is full");

endmodule

>>> hw/rtl/p2rgba_palette_mem.sv
// ----------------------------------------------------------------------------
// p2rgba_palette_mem
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module p2rgba_palette_mem (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [p2rgba_pkg::IDX_W-1:0]        wr_addr,
  input  p2rgba_pkg::pal_entry_t              wr_data,
  input  logic                                rd_en,
  input  logic [p2rgba_pkg::IDX_W-1:0]        rd_addr,
  output p2rgba_pkg::pal_entry_t              rd_data
);
  import p2rgba_pkg::*;

  pal_entry_t mem [PALETTE_ENTRIES];
  pal_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/p2rgba_format.sv
// ----------------------------------------------------------------------------
// p2rgba_format
// Output stage: orders the entry bytes, applies the alpha mode, holds the
// result until the sink takes it.
// ----------------------------------------------------------------------------
module p2rgba_format (
  input  logic                      clk,
  input  logic                      rst_n,
  input  p2rgba_pkg::lookup_stat_t  lookup,
  input  p2rgba_pkg::pal_entry_t    rd_data,
  input  logic                      output_alpha,
  output logic                      lookup_take,
  p2rgba_out_if.source              out_ch
);
  import p2rgba_pkg::*;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BYTE_W-1:0] first_r;
  logic [BYTE_W-1:0] second_r;
  logic [BYTE_W-1:0] third_r;
  logic [BYTE_W-1:0] alpha_r;
  logic              present_r;
  pal_entry_t        entry;
  logic              out_free;

  // lookup stage moves on when the output register is empty or draining
  assign out_free    = !out_valid_r || out_ch.ready;
  assign lookup_take = lookup.valid && out_free;

  // out-of-range pixels read as an all-zero entry
  assign entry = lookup.oor ? '0 : rd_data;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (lookup_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (lookup_take) begin
      first_r   <= entry.byte2;
      second_r  <= entry.byte1;
      third_r   <= entry.byte0;
      alpha_r   <= output_alpha ? entry.alpha : '0;
      present_r <= output_alpha;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.first_byte    = first_r;
  assign out_ch.second_byte   = second_r;
  assign out_ch.third_byte    = third_r;
  assign out_ch.alpha_byte    = alpha_r;
  assign out_ch.alpha_present = present_r;

  // three-byte results carry a zero fourth byte
  a_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !present_r |-> alpha_r == '0)
    else $error("alpha byte not zero in three-byte mode");

  // a stalled result is never overwritten by the lookup stage
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !lookup_take)
    else $error("lookup stage advanced into a stalled output");

  // a stalled result stays valid with its payload unchanged
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=>
      out_valid_r && $stable({first_r, second_r, third_r, alpha_r, present_r}))
    else $error("stalled result changed before it was taken");

endmodule
